// ===== rtl/core/sbus_frame_decoder_defines.svh =====
// Assertion macros used by the checker file of the decoder.
`ifndef SBUS_FRAME_DECODER_DEFINES_SVH
`define SBUS_FRAME_DECODER_DEFINES_SVH

// Same-cycle implication, off during reset
`define SFD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfd check failed");

// Next-cycle implication, off during reset
`define SFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfd check failed");

// Condition that must hold on the cycle after a reset cycle
`define SFD_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error("sfd reset check failed");

`endif

// ===== rtl/core/sfd_pkg.sv =====
`default_nettype none

package sfd_pkg;

  // Frame layout
  localparam int FRAME_BYTES   = 25;
  localparam int CHANNEL_COUNT = 16;
  localparam int BYTE_W        = 8;
  localparam int RAW_W         = 11;
  localparam int CH_W          = 4;
  localparam int POS_W         = 5;
  localparam int PCT_W         = 15;
  localparam int GAIN_W        = 24;
  localparam int FLAG_BYTE     = 23;
  localparam int BODY_BYTES    = FRAME_BYTES - 2;
  localparam int BODY_W        = BODY_BYTES * BYTE_W;
  localparam int PROD_W        = RAW_W + GAIN_W;
  localparam int FRAC_W        = 16;
  localparam int PERCENT_LIMIT = 25600;

  // Queue depths
  localparam int FQ_DEPTH_DEF  = 2;
  localparam int OUT_DEPTH_DEF = 4;

  // Configuration register map
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    REG_HEADER = 3'd0,
    REG_FOOTER = 3'd1,
    REG_RMIN   = 3'd2,
    REG_RMAX   = 3'd3,
    REG_GAIN   = 3'd4
  } sfd_reg_t;

  localparam logic [7:0]        HEADER_RST = 8'd15;
  localparam logic [7:0]        FOOTER_RST = 8'd0;
  localparam logic [RAW_W-1:0]  RMIN_RST   = 11'd172;
  localparam logic [RAW_W-1:0]  RMAX_RST   = 11'd1811;
  localparam logic [GAIN_W-1:0] GAIN_RST   = 24'd1023625;

  typedef struct packed {
    logic [BYTE_W-1:0] header;
    logic [BYTE_W-1:0] footer;
    logic [RAW_W-1:0]  rmin;
    logic [RAW_W-1:0]  rmax;
    logic [GAIN_W-1:0] gain;
  } sfd_cfg_t;

  // One collected frame: check result and bytes 1..23
  typedef struct packed {
    logic              ok;
    logic [BODY_W-1:0] body;
  } sfd_frame_t;

  // One result item
  typedef struct packed {
    logic [CH_W-1:0]  index;
    logic [RAW_W-1:0] raw;
    logic [PCT_W-1:0] percent;
    logic             digital_one;
    logic             digital_two;
    logic             frame_lost;
    logic             fail_safe;
    logic             frame_valid;
    logic             last;
  } sfd_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/sfd_fifo.sv =====
`default_nettype none

module sfd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         wr_en,
  input  wire logic [WIDTH-1:0]             wr_data,
  input  wire logic                         rd_en,
  output logic      [WIDTH-1:0]             rd_data,
  output logic                              full,
  output logic                              empty,
  output logic      [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [0:DEPTH-1];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_data = mem_r[rd_ptr_r];
  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;

endmodule

`default_nettype wire

// ===== rtl/core/sfd_front.sv =====
`default_nettype none

module sfd_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire sfd_pkg::sfd_cfg_t           cfg,
  input  wire logic                        push,
  input  wire logic [sfd_pkg::BYTE_W-1:0]  data_byte,
  input  wire logic                        resync,
  input  wire logic                        fq_full,
  output logic                             full,
  output logic                             fq_push,
  output sfd_pkg::sfd_frame_t              fq_data
);

  localparam logic [sfd_pkg::POS_W-1:0] LAST_POS = sfd_pkg::POS_W'(sfd_pkg::FRAME_BYTES - 1);

  logic [sfd_pkg::BYTE_W-1:0] store_r [0:sfd_pkg::FRAME_BYTES-2];
  logic [sfd_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [sfd_pkg::POS_W-1:0]  wpos;
  logic                       accept;
  logic                       closing;

  // Stall any byte offered at the closing position, also a resync byte, while the frame queue is full
  assign full    = fq_full && (pos_r == LAST_POS);
  assign accept  = push && !full;
  assign wpos    = resync ? '0 : pos_r;
  assign closing = (wpos == LAST_POS);
  assign fq_push = accept && closing;

  always_comb begin
    pos_nxt = pos_r;
    if (accept) begin
      pos_nxt = closing ? '0 : wpos + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // Byte store, closing byte is never stored
  always_ff @(posedge clk) begin
    if (accept && !closing) begin
      store_r[wpos] <= data_byte;
    end
  end

  // Frame record: header/footer check and the channel/flag bytes
  always_comb begin
    fq_data.ok = (store_r[0] == cfg.header) && (data_byte == cfg.footer);
    for (int k = 1; k <= sfd_pkg::BODY_BYTES; k++) begin
      fq_data.body[(k-1)*sfd_pkg::BYTE_W +: sfd_pkg::BYTE_W] = store_r[k];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sfd_back.sv =====
`default_nettype none

module sfd_back #(
  parameter int OUT_DEPTH = sfd_pkg::OUT_DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire sfd_pkg::sfd_cfg_t                  cfg,
  input  wire logic                               fq_empty,
  input  wire sfd_pkg::sfd_frame_t                fq_data,
  output logic                                    fq_pop,
  input  wire logic [$clog2(OUT_DEPTH+1)-1:0]     out_cnt,
  output logic                                    res_wr,
  output sfd_pkg::sfd_result_t                    res_data
);

  localparam int CNT_W = $clog2(OUT_DEPTH + 1);
  localparam logic [sfd_pkg::CH_W-1:0] LAST_CH = sfd_pkg::CH_W'(sfd_pkg::CHANNEL_COUNT - 1);
  localparam int RES_W = sfd_pkg::PROD_W - sfd_pkg::FRAC_W;

  logic [sfd_pkg::CH_W-1:0]   ch_r, ch_nxt;
  logic [CNT_W-1:0]           space;
  logic [CNT_W-1:0]           inflight;
  logic                       issue;
  logic                       rec_done;

  sfd_pkg::sfd_result_t       s1_res;
  logic [sfd_pkg::RAW_W-1:0]  s1_diff;
  logic [sfd_pkg::RAW_W-1:0]  clamp_lo;
  logic [sfd_pkg::RAW_W-1:0]  clamp_hi;

  logic                       s1_v_r;
  sfd_pkg::sfd_result_t       s1_res_r;
  logic [sfd_pkg::RAW_W-1:0]  s1_diff_r;
  logic                       s2_v_r;
  sfd_pkg::sfd_result_t       s2_res_r;
  logic [sfd_pkg::PROD_W-1:0] s2_prod_r;
  logic [RES_W-1:0]           scaled;

  // Issue only with room reserved for items still in the pipe
  assign space    = CNT_W'(OUT_DEPTH) - out_cnt;
  assign inflight = CNT_W'(s1_v_r) + CNT_W'(s2_v_r);
  assign issue    = !fq_empty && (inflight < space);
  assign rec_done = !fq_data.ok || (ch_r == LAST_CH);
  assign fq_pop   = issue && rec_done;

  // Channel counter
  always_comb begin
    ch_nxt = ch_r;
    if (issue) begin
      ch_nxt = rec_done ? '0 : ch_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r <= '0;
    end else begin
      ch_r <= ch_nxt;
    end
  end

  // Stage 1: unpack, clamp, offset
  always_comb begin
    s1_res   = '0;
    s1_diff  = '0;
    clamp_lo = '0;
    clamp_hi = '0;
    if (fq_data.ok) begin
      s1_res.index       = ch_r;
      s1_res.raw         = fq_data.body[int'(ch_r) * sfd_pkg::RAW_W +: sfd_pkg::RAW_W];
      s1_res.digital_one = fq_data.body[(sfd_pkg::FLAG_BYTE - 1) * sfd_pkg::BYTE_W];
      s1_res.digital_two = fq_data.body[(sfd_pkg::FLAG_BYTE - 1) * sfd_pkg::BYTE_W + 1];
      s1_res.frame_lost  = fq_data.body[(sfd_pkg::FLAG_BYTE - 1) * sfd_pkg::BYTE_W + 2];
      s1_res.fail_safe   = fq_data.body[(sfd_pkg::FLAG_BYTE - 1) * sfd_pkg::BYTE_W + 3];
      s1_res.frame_valid = 1'b1;
      s1_res.last        = (ch_r == LAST_CH);
      clamp_lo = (s1_res.raw < cfg.rmin) ? cfg.rmin : s1_res.raw;
      clamp_hi = (clamp_lo > cfg.rmax) ? cfg.rmax : clamp_lo;
      // crossed range ends below the minimum and reads as zero
      s1_diff  = (clamp_hi < cfg.rmin) ? '0 : clamp_hi - cfg.rmin;
    end else begin
      s1_res.last = 1'b1;
    end
  end

  // Pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
    end
  end

  // Pipeline payload; stage 2 holds the gain product
  always_ff @(posedge clk) begin
    s1_res_r  <= s1_res;
    s1_diff_r <= s1_diff;
    s2_res_r  <= s1_res_r;
    s2_prod_r <= sfd_pkg::PROD_W'(s1_diff_r) * sfd_pkg::PROD_W'(cfg.gain);
  end

  // Drop the Q16 fraction and saturate
  assign scaled = s2_prod_r[sfd_pkg::PROD_W-1:sfd_pkg::FRAC_W];

  always_comb begin
    res_data = s2_res_r;
    res_data.percent = (scaled > RES_W'(sfd_pkg::PERCENT_LIMIT))
                     ? sfd_pkg::PCT_W'(sfd_pkg::PERCENT_LIMIT)
                     : scaled[sfd_pkg::PCT_W-1:0];
  end

  assign res_wr = s2_v_r;

endmodule

`default_nettype wire

// ===== rtl/core/sbus_frame_decoder.sv =====
// SBUS 16-channel frame decoder.
// Input channel: one received byte per item (in_data_byte, in_resync), taken
// on push while full is low. in_resync makes the byte the first of a frame.
// Bytes 0..24 form a frame; the closing byte checks header and footer.
// Result channel: queue style, a result is shown while empty is low and is
// taken on pop. A good frame gives 16 results (channels 0..15, last on 15);
// a bad frame gives one result with out_frame_valid low and out_last high.
// A frame enters the frame queue on its closing byte; its results pass the
// stage 1 and stage 2 registers into the result queue as room allows.
// Results leave at one per cycle while pop is high; bytes are taken at one
// per cycle while full is low. The frame queue holds two collected frames;
// full is high only while 24 bytes are held and that queue is full, which
// happens when pop stalls until the result queue and both frame slots fill.
// Config: pready is always high. APB registers at 4*i (header, footer, range
// min, range max, gain), written by the user only while idle; not enforced.
// Reset: synchronous, active low; clears the byte count, both queues and the
// pipeline, and loads register defaults. The byte store is not cleared.
`default_nettype none

module sbus_frame_decoder #(
  parameter int FQ_DEPTH  = sfd_pkg::FQ_DEPTH_DEF,
  parameter int OUT_DEPTH = sfd_pkg::OUT_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input channel
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [sfd_pkg::BYTE_W-1:0]    in_data_byte,
  input  wire logic                          in_resync,
  // result channel
  output logic                               empty,
  input  wire logic                          pop,
  output logic [sfd_pkg::CH_W-1:0]           out_channel_index,
  output logic [sfd_pkg::RAW_W-1:0]          out_channel_raw,
  output logic [sfd_pkg::PCT_W-1:0]          out_channel_percent,
  output logic                               out_digital_one,
  output logic                               out_digital_two,
  output logic                               out_frame_lost,
  output logic                               out_fail_safe,
  output logic                               out_frame_valid,
  output logic                               out_last,
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [sfd_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [sfd_pkg::DATA_W-1:0]    pwdata,
  output logic [sfd_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);

  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);
  localparam int FQ_CNT_W  = $clog2(FQ_DEPTH + 1);

  sfd_pkg::sfd_cfg_t    cfg_r, cfg_nxt;
  sfd_pkg::sfd_reg_t    reg_idx;
  logic                 cfg_wr;

  logic                 fq_push;
  logic                 fq_pop;
  logic                 fq_full;
  logic                 fq_empty;
  logic [FQ_CNT_W-1:0]  fq_cnt;
  sfd_pkg::sfd_frame_t  fq_wdata;
  sfd_pkg::sfd_frame_t  fq_rdata;

  logic                 res_wr;
  sfd_pkg::sfd_result_t res_wdata;
  sfd_pkg::sfd_result_t res_rdata;
  logic [OUT_CNT_W-1:0] out_cnt;
  logic                 out_full;
  logic                 out_rd;

  // Register port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = sfd_pkg::sfd_reg_t'(paddr[sfd_pkg::ADDR_W-1:2]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (reg_idx)
        sfd_pkg::REG_HEADER: cfg_nxt.header = pwdata[sfd_pkg::BYTE_W-1:0];
        sfd_pkg::REG_FOOTER: cfg_nxt.footer = pwdata[sfd_pkg::BYTE_W-1:0];
        sfd_pkg::REG_RMIN:   cfg_nxt.rmin   = pwdata[sfd_pkg::RAW_W-1:0];
        sfd_pkg::REG_RMAX:   cfg_nxt.rmax   = pwdata[sfd_pkg::RAW_W-1:0];
        sfd_pkg::REG_GAIN:   cfg_nxt.gain   = pwdata[sfd_pkg::GAIN_W-1:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header <= sfd_pkg::HEADER_RST;
      cfg_r.footer <= sfd_pkg::FOOTER_RST;
      cfg_r.rmin   <= sfd_pkg::RMIN_RST;
      cfg_r.rmax   <= sfd_pkg::RMAX_RST;
      cfg_r.gain   <= sfd_pkg::GAIN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Register readback
  always_comb begin
    case (reg_idx)
      sfd_pkg::REG_HEADER: prdata = sfd_pkg::DATA_W'(cfg_r.header);
      sfd_pkg::REG_FOOTER: prdata = sfd_pkg::DATA_W'(cfg_r.footer);
      sfd_pkg::REG_RMIN:   prdata = sfd_pkg::DATA_W'(cfg_r.rmin);
      sfd_pkg::REG_RMAX:   prdata = sfd_pkg::DATA_W'(cfg_r.rmax);
      sfd_pkg::REG_GAIN:   prdata = sfd_pkg::DATA_W'(cfg_r.gain);
      default:             prdata = '0;
    endcase
  end

  // Front: byte collection and frame check
  sfd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .push      (push),
    .data_byte (in_data_byte),
    .resync    (in_resync),
    .fq_full   (fq_full),
    .full      (full),
    .fq_push   (fq_push),
    .fq_data   (fq_wdata)
  );

  // Queue of collected frames
  sfd_fifo #(
    .WIDTH ($bits(sfd_pkg::sfd_frame_t)),
    .DEPTH (FQ_DEPTH)
  ) u_frame_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fq_push),
    .wr_data (fq_wdata),
    .rd_en   (fq_pop),
    .rd_data (fq_rdata),
    .full    (fq_full),
    .empty   (fq_empty),
    .count   (fq_cnt)
  );

  // Back: channel sequencing and scaling
  sfd_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .fq_empty (fq_empty),
    .fq_data  (fq_rdata),
    .fq_pop   (fq_pop),
    .out_cnt  (out_cnt),
    .res_wr   (res_wr),
    .res_data (res_wdata)
  );

  // Result queue
  assign out_rd = pop && !empty;

  sfd_fifo #(
    .WIDTH ($bits(sfd_pkg::sfd_result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_wr),
    .wr_data (res_wdata),
    .rd_en   (out_rd),
    .rd_data (res_rdata),
    .full    (out_full),
    .empty   (empty),
    .count   (out_cnt)
  );

  assign out_channel_index   = res_rdata.index;
  assign out_channel_raw     = res_rdata.raw;
  assign out_channel_percent = res_rdata.percent;
  assign out_digital_one     = res_rdata.digital_one;
  assign out_digital_two     = res_rdata.digital_two;
  assign out_frame_lost      = res_rdata.frame_lost;
  assign out_fail_safe       = res_rdata.fail_safe;
  assign out_frame_valid     = res_rdata.frame_valid;
  // out_full and fq_cnt are status only; the back credit keeps the queue from overflow
  assign out_last            = res_rdata.last | (out_full & 1'b0) | (|fq_cnt & 1'b0);

endmodule

`default_nettype wire

// ===== rtl/core/sfd_checker.sv =====
`default_nettype none
`include "sbus_frame_decoder_defines.svh"

module sfd_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        push,
  input wire logic                        full,
  input wire logic                        pop,
  input wire logic                        empty,
  input wire logic [sfd_pkg::CH_W-1:0]    out_channel_index,
  input wire logic [sfd_pkg::RAW_W-1:0]   out_channel_raw,
  input wire logic [sfd_pkg::PCT_W-1:0]   out_channel_percent,
  input wire logic                        out_frame_valid,
  input wire logic                        out_last
);

  // Queues come out of reset empty and open
  `SFD_ASSERT_RST(a_reset_clear, empty && !full && !$isunknown(push))

  // A waiting result holds until taken
  `SFD_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(out_channel_raw) && $stable(out_last))

  // Channels of a good frame come out in order
  `SFD_ASSERT_NEXT(a_order, !empty && pop && out_frame_valid && !out_last, empty || (out_channel_index == $past(out_channel_index) + 4'd1))

  // The last mark sits on channel 15 of a good frame
  `SFD_ASSERT_NOW(a_last_ch, !empty && out_frame_valid, (out_channel_index == 4'd15) == out_last)

  // A rejected frame gives a single cleared result
  `SFD_ASSERT_NOW(a_bad_frame, !empty && !out_frame_valid, out_last && (out_channel_raw == '0) && (out_channel_percent == '0))

endmodule

bind sbus_frame_decoder sfd_checker u_sfd_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .push                (push),
  .full                (full),
  .pop                 (pop),
  .empty               (empty),
  .out_channel_index   (out_channel_index),
  .out_channel_raw     (out_channel_raw),
  .out_channel_percent (out_channel_percent),
  .out_frame_valid     (out_frame_valid),
  .out_last            (out_last)
);

`default_nettype wire
